// ----- rtl/dctp_pkg.sv -----
package dctp_pkg;

    typedef enum logic [2:0] {
        SUB_LETTER,
        SUB_COLON,
        SUB_SPACE,
        SUB_SIGN,
        SUB_DIGITS
    } sub_phase_t;

    typedef enum logic [3:0] {
        CMD_HALT       = 4'd0,
        CMD_FWD        = 4'd1,
        CMD_BACK       = 4'd2,
        CMD_TURN_LEFT  = 4'd3,
        CMD_TURN_RIGHT = 4'd4,
        CMD_FWD_LEFT   = 4'd5,
        CMD_FWD_RIGHT  = 4'd6,
        CMD_BACK_LEFT  = 4'd7,
        CMD_BACK_RIGHT = 4'd8
    } cmd_code_t;

    localparam int FIELD_COUNT = 4;

    localparam logic [1:0] FIELD_F = 2'd0;
    localparam logic [1:0] FIELD_B = 2'd1;
    localparam logic [1:0] FIELD_R = 2'd2;
    localparam logic [1:0] FIELD_L = 2'd3;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_STOP  = 8'h53;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HT    = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } dctp_step_t;

    typedef struct packed {
        cmd_code_t         command_code;
        logic signed [7:0] forward_value;
        logic signed [7:0] backward_value;
        logic signed [7:0] right_value;
        logic signed [7:0] left_value;
    } dctp_cmd_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_HT && c <= CHAR_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic [7:0] letter_of(input logic [1:0] k);
        logic [7:0] l;
        unique case (k)
            FIELD_F: l = 8'h46;
            FIELD_B: l = 8'h42;
            FIELD_R: l = 8'h52;
            default: l = 8'h4C;
        endcase
        return l;
    endfunction

endpackage

// ----- rtl/dctp_byte_if.sv -----
interface dctp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/dctp_cmd_if.sv -----
interface dctp_cmd_if;
    logic              valid;
    logic              ready;
    logic [3:0]        command_code;
    logic signed [7:0] forward_value;
    logic signed [7:0] backward_value;
    logic signed [7:0] right_value;
    logic signed [7:0] left_value;

    modport source (
        output valid, output command_code, output forward_value,
        output backward_value, output right_value, output left_value,
        input ready
    );
    modport sink (
        input valid, input command_code, input forward_value,
        input backward_value, input right_value, input left_value,
        output ready
    );
endinterface

// ----- rtl/drive_command_text_parser_core.sv -----
// channel   dir  payload                                     transfer
// text      in   data_byte[8], last_byte                     one character
// command   out  command_code[4], forward/backward/right/    at most one drive command
//                left_value[8] signed                        per message end
// one character per cycle while no stalled command holds back a last byte; a
// taken byte is loaded into the input register, then parsed into the output
// register, from which the command is offered
// rst_n clears the parse state and the valid flags of both registers
// a stalled command only holds back a later last byte; other bytes keep flowing
module drive_command_text_parser_core #(
    parameter int MESSAGE_BYTES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    dctp_byte_if.sink         text,
    dctp_cmd_if.source        command
);

    logic                 s1_valid_reg, s1_valid_next;
    dctp_pkg::dctp_step_t s1_step_reg, s1_step_next;
    logic                 out_valid_reg, out_valid_next;
    dctp_pkg::dctp_cmd_t  out_cmd_reg, out_cmd_next;

    logic                 advance;
    logic                 result_valid;
    dctp_pkg::dctp_cmd_t  result;

    assign advance = s1_valid_reg
                     && (!s1_step_reg.last_byte || !out_valid_reg || command.ready);
    assign text.ready = !s1_valid_reg || advance;

    dctp_parser #(
        .MESSAGE_BYTES (MESSAGE_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_valid   (advance),
        .step         (s1_step_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_step_next  = s1_step_reg;
        if (text.ready)
        begin
            s1_valid_next = text.valid;
            s1_step_next  = '{text.data_byte, text.last_byte};
        end

        out_valid_next = out_valid_reg;
        out_cmd_next   = out_cmd_reg;
        if (advance && result_valid)
        begin
            out_valid_next = 1'b1;
            out_cmd_next   = result;
        end
        else if (command.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_step_reg <= s1_step_next;
        out_cmd_reg <= out_cmd_next;
    end

    assign command.valid          = out_valid_reg;
    assign command.command_code   = out_cmd_reg.command_code;
    assign command.forward_value  = out_cmd_reg.forward_value;
    assign command.backward_value = out_cmd_reg.backward_value;
    assign command.right_value    = out_cmd_reg.right_value;
    assign command.left_value     = out_cmd_reg.left_value;

    // a command only comes from a parsed last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && s1_step_reg.last_byte))
        else $error("command without message end");

    // a held byte is not dropped or changed
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_step_reg))
        else $error("held byte lost");

    // a pending command is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !command.ready |=> out_valid_reg && $stable(out_cmd_reg))
        else $error("pending command overwritten");

endmodule

// ----- rtl/dctp_parser.sv -----
module dctp_parser #(
    parameter int MESSAGE_BYTES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_valid,
    input  dctp_pkg::dctp_step_t  step,
    output logic                  result_valid,
    output dctp_pkg::dctp_cmd_t   result
);

    localparam int CountW = $clog2(MESSAGE_BYTES + 1);
    localparam logic [CountW-1:0] CountMax = CountW'(MESSAGE_BYTES);

    dctp_pkg::sub_phase_t sub_reg, sub_next;
    logic [1:0]        field_reg, field_next;
    logic              done_reg, done_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              stop_reg, stop_next;
    logic              failed_reg, failed_next;
    logic              ended_reg, ended_next;
    logic [7:0]        accum_reg, accum_next;
    logic              neg_reg, neg_next;
    logic              nz_reg, nz_next;
    logic [7:0]        values_reg [dctp_pkg::FIELD_COUNT];
    logic [7:0]        values_next [dctp_pkg::FIELD_COUNT];
    logic [dctp_pkg::FIELD_COUNT-1:0] pos_reg, pos_next, fnz_reg, fnz_next;

    logic [7:0] c;
    logic [7:0] digit_value;
    logic [7:0] accum_added;
    logic       take;
    logic       ok;
    logic [7:0] fin_val [dctp_pkg::FIELD_COUNT];
    logic [dctp_pkg::FIELD_COUNT-1:0] fin_pos, fin_nz;
    logic       code_found;
    dctp_pkg::cmd_code_t code;

    always_comb
    begin
        c           = step.data_byte;
        digit_value = c - dctp_pkg::CHAR_ZERO;
        accum_added = {accum_reg[4:0], 3'b000} + {accum_reg[6:0], 1'b0}
                      + {4'b0000, digit_value[3:0]};

        sub_next    = sub_reg;
        field_next  = field_reg;
        done_next   = done_reg;
        count_next  = count_reg;
        stop_next   = stop_reg;
        failed_next = failed_reg;
        ended_next  = ended_reg;
        accum_next  = accum_reg;
        neg_next    = neg_reg;
        nz_next     = nz_reg;
        values_next = values_reg;
        pos_next    = pos_reg;
        fnz_next    = fnz_reg;

        take = step_valid && !ended_reg && (count_reg < CountMax);

        if (take)
        begin
            count_next = count_reg + 1'b1;
            if (c == dctp_pkg::CHAR_NUL)
            begin
                ended_next = 1'b1;
            end
            else
            begin
                if (count_reg == '0 && c == dctp_pkg::CHAR_STOP)
                begin
                    stop_next = 1'b1;
                end
                if (!stop_next && !failed_reg && !done_reg)
                begin
                    unique case (sub_reg)
                        dctp_pkg::SUB_LETTER:
                        begin
                            if (field_reg != dctp_pkg::FIELD_F && dctp_pkg::is_space(c))
                            begin
                                sub_next = dctp_pkg::SUB_LETTER;
                            end
                            else if (c == dctp_pkg::letter_of(field_reg))
                            begin
                                sub_next = dctp_pkg::SUB_COLON;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        dctp_pkg::SUB_COLON:
                        begin
                            if (c == dctp_pkg::CHAR_COLON)
                            begin
                                sub_next = dctp_pkg::SUB_SPACE;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        dctp_pkg::SUB_SPACE:
                        begin
                            if (dctp_pkg::is_space(c))
                            begin
                                sub_next = dctp_pkg::SUB_SPACE;
                            end
                            else if (c == dctp_pkg::CHAR_PLUS || c == dctp_pkg::CHAR_MINUS)
                            begin
                                neg_next = (c == dctp_pkg::CHAR_MINUS);
                                sub_next = dctp_pkg::SUB_SIGN;
                            end
                            else if (dctp_pkg::is_digit(c))
                            begin
                                accum_next = accum_added;
                                nz_next    = nz_reg || (digit_value[3:0] != 4'd0);
                                sub_next   = dctp_pkg::SUB_DIGITS;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        dctp_pkg::SUB_SIGN:
                        begin
                            if (dctp_pkg::is_digit(c))
                            begin
                                accum_next = accum_added;
                                nz_next    = nz_reg || (digit_value[3:0] != 4'd0);
                                sub_next   = dctp_pkg::SUB_DIGITS;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (dctp_pkg::is_digit(c))
                            begin
                                accum_next = accum_added;
                                nz_next    = nz_reg || (digit_value[3:0] != 4'd0);
                            end
                            else
                            begin
                                // close the number and look at the next letter
                                values_next[field_reg] = neg_reg ? 8'(8'd0 - accum_reg)
                                                                 : accum_reg;
                                fnz_next[field_reg] = nz_reg;
                                pos_next[field_reg] = nz_reg && !neg_reg;
                                accum_next = '0;
                                neg_next   = 1'b0;
                                nz_next    = 1'b0;
                                if (field_reg == dctp_pkg::FIELD_L)
                                begin
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    field_next = field_reg + 1'b1;
                                    sub_next   = dctp_pkg::SUB_LETTER;
                                    if (dctp_pkg::is_space(c))
                                    begin
                                        sub_next = dctp_pkg::SUB_LETTER;
                                    end
                                    else if (c == dctp_pkg::letter_of(field_next))
                                    begin
                                        sub_next = dctp_pkg::SUB_COLON;
                                    end
                                    else
                                    begin
                                        failed_next = 1'b1;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
        end

        // end of message: close a number still open in the last field
        fin_val = values_next;
        fin_pos = pos_next;
        fin_nz  = fnz_next;
        ok      = done_next;
        if (!done_next && field_next == dctp_pkg::FIELD_L && sub_next == dctp_pkg::SUB_DIGITS)
        begin
            fin_val[dctp_pkg::FIELD_L] = neg_next ? 8'(8'd0 - accum_next) : accum_next;
            fin_nz[dctp_pkg::FIELD_L]  = nz_next;
            fin_pos[dctp_pkg::FIELD_L] = nz_next && !neg_next;
            ok = 1'b1;
        end

        code_found = 1'b1;
        priority if (fin_nz == '0)
            code = dctp_pkg::CMD_HALT;
        else if (fin_pos[dctp_pkg::FIELD_F] && fin_pos[dctp_pkg::FIELD_L])
            code = dctp_pkg::CMD_FWD_LEFT;
        else if (fin_pos[dctp_pkg::FIELD_F] && fin_pos[dctp_pkg::FIELD_R])
            code = dctp_pkg::CMD_FWD_RIGHT;
        else if (fin_pos[dctp_pkg::FIELD_B] && fin_pos[dctp_pkg::FIELD_L])
            code = dctp_pkg::CMD_BACK_LEFT;
        else if (fin_pos[dctp_pkg::FIELD_B] && fin_pos[dctp_pkg::FIELD_R])
            code = dctp_pkg::CMD_BACK_RIGHT;
        else if (fin_pos[dctp_pkg::FIELD_F])
            code = dctp_pkg::CMD_FWD;
        else if (fin_pos[dctp_pkg::FIELD_B])
            code = dctp_pkg::CMD_BACK;
        else if (fin_pos[dctp_pkg::FIELD_L])
            code = dctp_pkg::CMD_TURN_LEFT;
        else if (fin_pos[dctp_pkg::FIELD_R])
            code = dctp_pkg::CMD_TURN_RIGHT;
        else
        begin
            code       = dctp_pkg::CMD_HALT;
            code_found = 1'b0;
        end

        result_valid = step_valid && step.last_byte
                       && (stop_next || (!failed_next && ok && code_found));
        if (stop_next)
        begin
            result = '{dctp_pkg::CMD_HALT, 8'sd0, 8'sd0, 8'sd0, 8'sd0};
        end
        else
        begin
            result.command_code   = code;
            result.forward_value  = fin_val[dctp_pkg::FIELD_F];
            result.backward_value = fin_val[dctp_pkg::FIELD_B];
            result.right_value    = fin_val[dctp_pkg::FIELD_R];
            result.left_value     = fin_val[dctp_pkg::FIELD_L];
        end

        if (step_valid && step.last_byte)
        begin
            sub_next    = dctp_pkg::SUB_LETTER;
            field_next  = dctp_pkg::FIELD_F;
            done_next   = 1'b0;
            count_next  = '0;
            stop_next   = 1'b0;
            failed_next = 1'b0;
            ended_next  = 1'b0;
            accum_next  = '0;
            neg_next    = 1'b0;
            nz_next     = 1'b0;
            for (int i = 0; i < dctp_pkg::FIELD_COUNT; i++)
            begin
                values_next[i] = '0;
            end
            pos_next = '0;
            fnz_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg    <= dctp_pkg::SUB_LETTER;
            field_reg  <= dctp_pkg::FIELD_F;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            stop_reg   <= 1'b0;
            failed_reg <= 1'b0;
            ended_reg  <= 1'b0;
            accum_reg  <= '0;
            neg_reg    <= 1'b0;
            nz_reg     <= 1'b0;
            for (int i = 0; i < dctp_pkg::FIELD_COUNT; i++)
            begin
                values_reg[i] <= '0;
            end
            pos_reg    <= '0;
            fnz_reg    <= '0;
        end
        else
        begin
            sub_reg    <= sub_next;
            field_reg  <= field_next;
            done_reg   <= done_next;
            count_reg  <= count_next;
            stop_reg   <= stop_next;
            failed_reg <= failed_next;
            ended_reg  <= ended_next;
            accum_reg  <= accum_next;
            neg_reg    <= neg_next;
            nz_reg     <= nz_next;
            values_reg <= values_next;
            pos_reg    <= pos_next;
            fnz_reg    <= fnz_next;
        end
    end

    // message end puts the parser back at its start
    assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && step.last_byte |=> count_reg == '0 && !stop_reg && !failed_reg
            && !done_reg && sub_reg == dctp_pkg::SUB_LETTER)
        else $error("parser state not cleared after message end");

    // stop flag only after a counted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> count_reg != '0)
        else $error("stop flag without stored byte");

    // a positive field is always nonzero
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg & ~fnz_reg) == '0)
        else $error("positive field marked zero");

endmodule

// ----- test/testbench.sv -----
module testbench;
    import dctp_pkg::*;

    localparam int MSG_BYTES    = 64;
    localparam int RANDOM_BYTES = 780;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT      = 30;
    localparam int SIDE_TEXT    = 0;
    localparam int SIDE_CMD     = 1;

    localparam logic [7:0] FIELD_LETTERS [FIELD_COUNT] = '{"F", "B", "R", "L"};

    class command_tracker;
        dctp_cmd_t  expected_cmds[$];
        int         failures;
        int         field_idx;
        sub_phase_t sub;
        bit         all_done;
        int         count;
        bit         stop_seen;
        bit         failed;
        bit         ended;
        logic [7:0] accum;
        bit         neg;
        bit         nonzero;
        logic [7:0] vals [FIELD_COUNT];
        bit         pos [FIELD_COUNT];
        bit         nz [FIELD_COUNT];

        function new();
            failures = 0;
            clear_message();
        endfunction

        function void clear_message();
            field_idx = 0;
            sub = SUB_LETTER;
            all_done = 0;
            count = 0;
            stop_seen = 0;
            failed = 0;
            ended = 0;
            accum = '0;
            neg = 0;
            nonzero = 0;
            for (int i = 0; i < FIELD_COUNT; i++)
            begin
                vals[i] = '0;
                pos[i] = 0;
                nz[i] = 0;
            end
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CHAR_SPACE || (c >= CHAR_HT && c <= CHAR_CR);
        endfunction

        function bit is_numeral(logic [7:0] c);
            return c >= CHAR_ZERO && c <= CHAR_NINE;
        endfunction

        function void add_digit(logic [7:0] c);
            logic [7:0] d;
            d = c - CHAR_ZERO;
            accum = accum * 8'd10 + d;
            if (d != 8'd0)
                nonzero = 1;
        endfunction

        function void commit_field(int k);
            vals[k] = neg ? 8'd0 - accum : accum;
            nz[k] = nonzero;
            pos[k] = nonzero && !neg;
            accum = '0;
            neg = 0;
            nonzero = 0;
        endfunction

        function void match_letter(logic [7:0] c);
            if (field_idx > 0 && is_blank(c))
                return;
            if (c == FIELD_LETTERS[field_idx])
                sub = SUB_COLON;
            else
                failed = 1;
        endfunction

        function void parse_char(logic [7:0] c);
            if (all_done)
                return;
            case (sub)
                SUB_LETTER: match_letter(c);
                SUB_COLON:
                begin
                    if (c == CHAR_COLON)
                        sub = SUB_SPACE;
                    else
                        failed = 1;
                end
                SUB_SPACE:
                begin
                    if (is_blank(c))
                        return;
                    if (c == CHAR_PLUS || c == CHAR_MINUS)
                    begin
                        neg = (c == CHAR_MINUS);
                        sub = SUB_SIGN;
                    end
                    else if (is_numeral(c))
                    begin
                        add_digit(c);
                        sub = SUB_DIGITS;
                    end
                    else
                        failed = 1;
                end
                SUB_SIGN:
                begin
                    if (is_numeral(c))
                    begin
                        add_digit(c);
                        sub = SUB_DIGITS;
                    end
                    else
                        failed = 1;
                end
                default:
                begin
                    if (is_numeral(c))
                        add_digit(c);
                    else
                    begin
                        commit_field(field_idx);
                        if (field_idx == FIELD_COUNT - 1)
                            all_done = 1;
                        else
                        begin
                            field_idx++;
                            sub = SUB_LETTER;
                            match_letter(c);
                        end
                    end
                end
            endcase
        endfunction

        function void classify();
            cmd_code_t code;
            bit found;
            found = 1;
            code = CMD_HALT;
            if (!(nz[FIELD_F] || nz[FIELD_B] || nz[FIELD_R] || nz[FIELD_L]))
                code = CMD_HALT;
            else if (pos[FIELD_F] && pos[FIELD_L])
                code = CMD_FWD_LEFT;
            else if (pos[FIELD_F] && pos[FIELD_R])
                code = CMD_FWD_RIGHT;
            else if (pos[FIELD_B] && pos[FIELD_L])
                code = CMD_BACK_LEFT;
            else if (pos[FIELD_B] && pos[FIELD_R])
                code = CMD_BACK_RIGHT;
            else if (pos[FIELD_F])
                code = CMD_FWD;
            else if (pos[FIELD_B])
                code = CMD_BACK;
            else if (pos[FIELD_L])
                code = CMD_TURN_LEFT;
            else if (pos[FIELD_R])
                code = CMD_TURN_RIGHT;
            else
                found = 0;
            if (found)
                expected_cmds.push_back('{command_code: code,
                                          forward_value: vals[FIELD_F],
                                          backward_value: vals[FIELD_B],
                                          right_value: vals[FIELD_R],
                                          left_value: vals[FIELD_L]});
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            if (!ended && count < MSG_BYTES)
            begin
                if (c == CHAR_NUL)
                    ended = 1;
                else
                begin
                    if (count == 0 && c == CHAR_STOP)
                        stop_seen = 1;
                    if (!stop_seen && !failed)
                        parse_char(c);
                end
                count++;
            end
            if (!last)
                return;
            if (stop_seen)
                expected_cmds.push_back('{command_code: CMD_HALT, forward_value: 8'sd0,
                                          backward_value: 8'sd0, right_value: 8'sd0,
                                          left_value: 8'sd0});
            else if (!failed)
            begin
                // fourth number still open at the end of the message
                if (!all_done && field_idx == FIELD_COUNT - 1 && sub == SUB_DIGITS)
                begin
                    commit_field(FIELD_COUNT - 1);
                    all_done = 1;
                end
                if (all_done)
                    classify();
            end
            clear_message();
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected 0x%02h actual 0x%02h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_command(dctp_cmd_t got);
            dctp_cmd_t want;
            if (expected_cmds.size() == 0)
            begin
                $display("%0t: command expected none actual code %0d", $time,
                         got.command_code);
                failures++;
                return;
            end
            want = expected_cmds.pop_front();
            compare_field("command_code", 8'(want.command_code), 8'(got.command_code));
            compare_field("forward_value", want.forward_value, got.forward_value);
            compare_field("backward_value", want.backward_value, got.backward_value);
            compare_field("right_value", want.right_value, got.right_value);
            compare_field("left_value", want.left_value, got.left_value);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   delivered_count = 0;
    bit   quiet_side [2];
    logic [7:0] msg_text[$];
    command_tracker tracker = new();

    dctp_byte_if text_ch();
    dctp_cmd_if  cmd_ch();

    drive_command_text_parser_core #(
        .MESSAGE_BYTES(MSG_BYTES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .text(text_ch),
        .command(cmd_ch)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int draw_gap(int side);
        if ($urandom_range(0, 29) == 0)
            quiet_side[side] = !quiet_side[side];
        return quiet_side[side] ? 0 : $urandom_range(0, 11);
    endfunction

    // '~' stands for a zero byte and '^' for 0xff
    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            if (s[i] == "~")
                msg_text.push_back(CHAR_NUL);
            else if (s[i] == "^")
                msg_text.push_back(8'hFF);
            else
                msg_text.push_back(s[i]);
        end
    endtask

    task automatic push_blanks();
        int n;
        repeat ($urandom_range(0, 2))
        begin
            n = $urandom_range(0, 5);
            msg_text.push_back(n == 5 ? CHAR_SPACE : CHAR_HT + 8'(n));
        end
    endtask

    task automatic push_number();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            msg_text.push_back(CHAR_PLUS);
        else if (r == 1)
            msg_text.push_back(CHAR_MINUS);
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) msg_text.push_back(CHAR_ZERO);
        else
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(4, 12) : $urandom_range(1, 3))
                msg_text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic build_random_message();
        int kind;
        int n;
        int cut;
        msg_text.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            msg_text.push_back(CHAR_STOP);
            repeat ($urandom_range(0, 5)) msg_text.push_back(8'($urandom));
        end
        else if (kind < 20)
            repeat ($urandom_range(1, 8)) msg_text.push_back(8'($urandom));
        else
        begin
            for (int k = 0; k < FIELD_COUNT; k++)
            begin
                if (k > 0)
                    push_blanks();
                msg_text.push_back(FIELD_LETTERS[k]);
                msg_text.push_back(CHAR_COLON);
                push_blanks();
                push_number();
            end
            if ($urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, 4)) msg_text.push_back(8'($urandom));
            n = $urandom_range(0, 99);
            if (n < 10)
                msg_text[$urandom_range(0, msg_text.size() - 1)] = 8'($urandom);
            else if (n < 15)
                msg_text.insert($urandom_range(0, msg_text.size() - 1), CHAR_NUL);
            else if (n < 20)
                repeat (MSG_BYTES) msg_text.push_back(8'($urandom));
            else if (n < 28)
            begin
                cut = $urandom_range(1, msg_text.size());
                while (msg_text.size() > cut)
                    void'(msg_text.pop_back());
            end
        end
    endtask

    task automatic send_byte(logic [7:0] c, logic last);
        int gap;
        gap = draw_gap(SIDE_TEXT);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_ch.valid <= 1'b1;
        text_ch.data_byte <= c;
        text_ch.last_byte <= last;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        tracker.note_byte(c, last);
        @(negedge clk);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_text.size(); i++)
            send_byte(msg_text[i], i == msg_text.size() - 1);
        msg_text.delete();
    endtask

    initial
    begin : text_source
        string directed [$];
        int sent;
        text_ch.valid = 1'b0;
        text_ch.data_byte = '0;
        text_ch.last_byte = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed = '{"S", "~", "F:0 B:0 R:0 L:-0", "F:1 B:0 R:0 L:1", "F:2B:0R:3L:0",
                     "F:0B:+4R:0L:5", "F:0B:6R:7L:0", "F:8B:0R:0L:0", "F:0B:9R:0L:0",
                     "F:0B:0R:0L:10", "F:0B:0R:11L:0", "F:-1 B:-2 R:-3 L:-4",
                     "F:\t256\n B: -300\tR:\n0 L:0^ x", "F;1", "F:1 B:2", "F:-B:1",
                     "F:1B:2R:3L:4~S", "F:1B:1~R:1L:1", "F:1 S", "F:1B:1R:1L:1S"};
        foreach (directed[i])
        begin
            push_text(directed[i]);
            send_message();
        end
        // digits running past the buffer size
        push_text("F:0B:0R:0L:");
        repeat (60) msg_text.push_back(CHAR_ZERO + 8'd7);
        send_message();

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            build_random_message();
            sent += msg_text.size();
            send_message();
        end
        text_ch.valid <= 1'b0;

        while (tracker.expected_cmds.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : command_sink
        dctp_cmd_t got;
        int gap;
        bit held;
        held = 0;
        cmd_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(SIDE_CMD);
            // long stall so the output backs up into the text channel
            if (delivered_count == HOLD_AT && !held)
            begin
                gap = LONG_HOLD;
                held = 1;
            end
            if (gap > 0)
            begin
                cmd_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            cmd_ch.ready <= 1'b1;
            @(posedge clk);
            while (!cmd_ch.valid)
                @(posedge clk);
            got.command_code = cmd_code_t'(cmd_ch.command_code);
            got.forward_value = cmd_ch.forward_value;
            got.backward_value = cmd_ch.backward_value;
            got.right_value = cmd_ch.right_value;
            got.left_value = cmd_ch.left_value;
            tracker.check_command(got);
            delivered_count++;
            @(negedge clk);
        end
    end

endmodule

// ----- filelist.f -----
rtl/dctp_pkg.sv
rtl/dctp_byte_if.sv
rtl/dctp_cmd_if.sv
rtl/dctp_parser.sv
rtl/drive_command_text_parser_core.sv
test/testbench.sv
